[hw/rtl/huffman_code_builder_assert.svh]
// Assertion macros shared by the block.
`ifndef HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HUFFMAN_CODE_BUILDER_ASSERT_SVH
`define HCB_ASSERT_IMPL(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (c)) \
        else $error("hcb check failed");
`define HCB_ASSERT_NEXT(lbl, a, c) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (c)) \
        else $error("hcb check failed");
`endif

[hw/rtl/hcb_pkg.sv]
package hcb_pkg;
    localparam int MaxSymbols = 64;
    localparam int FreqBits   = 24;
    localparam int NodeCount  = 2 * MaxSymbols - 1;
    localparam int CodeMaxLen = 48;
    localparam int LeafW      = $clog2(MaxSymbols);
    localparam int NodeW      = $clog2(NodeCount);
    localparam int CntW       = LeafW + 1;
    localparam int WeightW    = 32;
endpackage

[hw/rtl/hcb_ram.sv]
module hcb_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[hw/rtl/huffman_code_builder.sv]
// Loading takes one cycle per beat, and a beat that is not the last gives no result.
// After the last beat, ready stays low until the last code beat is in the output register.
// With n loaded pairs the block sorts them, sets up the list of n nodes and merges them;
// building each code stalls while the beat in the output register waits to be taken.
// Synchronous active-low reset returns to loading with an empty store and no beat pending.
module huffman_code_builder
    import hcb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // symbol[7:0], frequency[31:8]
    input  logic        s_axis_tlast,   // last_symbol
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // code_symbol[7:0], code_bits[55:8], code_length[61:56]
    output logic        m_axis_tlast    // last_code
);
    typedef enum logic [4:0] {
        S_LOAD, S_SO_KEY, S_SO_KEYW, S_SO_CMP, S_SO_PUT,
        S_WL_INIT, S_MG_RDA, S_MG_RDB, S_MG_WA, S_MG_WB, S_MG_SH, S_MG_SCAN,
        S_MG_SCANL, S_MG_SCANW, S_MG_INS, S_MG_INSW, S_CD_START, S_CD_SYM,
        S_CD_RD, S_CD_STEP, S_CD_OUT
    } t_state;

    t_state r_state;
    logic [CntW-1:0] r_cnt, r_i, r_j, r_len, r_pos, r_k;
    logic [NodeW-1:0] r_next, r_a, r_b, r_node;
    logic [WeightW-1:0] r_w, r_wa;
    logic [7:0] r_s;
    logic [47:0] r_bits;
    logic [6:0] r_clen;
    logic [63:0] r_tdata;
    logic r_tlast, r_tvalid;

    // Weight RAM (nodes), symbol RAM (leaves), parent+bit RAM, work list RAM.
    logic w_we, s_we, p_we, l_we;
    logic [NodeW-1:0] w_wa, w_ra, p_wa, p_ra;
    logic [LeafW-1:0] s_wa, s_ra, l_wa, l_ra;
    logic [WeightW-1:0] w_wd, w_rd;
    logic [7:0] s_wd, s_rd;
    logic [NodeW:0] p_wd, p_rd;
    logic [NodeW-1:0] l_wd, l_rd;

    hcb_ram #(.Width(WeightW), .Depth(NodeCount)) u_wt (.i_clk, .i_we(w_we),
        .i_waddr(w_wa), .i_wdata(w_wd), .i_raddr(w_ra), .o_rdata(w_rd));
    hcb_ram #(.Width(8), .Depth(MaxSymbols)) u_sym (.i_clk, .i_we(s_we),
        .i_waddr(s_wa), .i_wdata(s_wd), .i_raddr(s_ra), .o_rdata(s_rd));
    hcb_ram #(.Width(NodeW + 1), .Depth(NodeCount)) u_par (.i_clk, .i_we(p_we),
        .i_waddr(p_wa), .i_wdata(p_wd), .i_raddr(p_ra), .o_rdata(p_rd));
    hcb_ram #(.Width(NodeW), .Depth(MaxSymbols)) u_wl (.i_clk, .i_we(l_we),
        .i_waddr(l_wa), .i_wdata(l_wd), .i_raddr(l_ra), .o_rdata(l_rd));

    logic in_acc;
    logic out_load;
    logic [NodeW-1:0] root;
    logic [5:0] code_len;
    assign s_axis_tready = (r_state == S_LOAD);
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign root = NodeW'({r_cnt, 1'b0} - 8'd2);
    assign out_load = (r_state == S_CD_OUT) && (!r_tvalid || m_axis_tready);
    assign code_len = (r_clen > 7'(CodeMaxLen)) ? 6'(CodeMaxLen) : r_clen[5:0];

    always_comb begin
        w_we = 1'b0; w_wa = '0; w_wd = '0; w_ra = '0;
        s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
        p_we = 1'b0; p_wa = '0; p_wd = '0; p_ra = r_node;
        l_we = 1'b0; l_wa = '0; l_wd = '0; l_ra = '0;
        case (r_state)
            S_LOAD: begin
                w_we = in_acc && (r_cnt < CntW'(MaxSymbols));
                s_we = in_acc && (r_cnt < CntW'(MaxSymbols));
                w_wa = NodeW'(r_cnt); s_wa = LeafW'(r_cnt);
                w_wd = WeightW'(s_axis_tdata[8 +: FreqBits]);
                s_wd = s_axis_tdata[7:0];
            end
            S_SO_KEY: begin
                w_ra = NodeW'(r_i); s_ra = LeafW'(r_i);
            end
            S_SO_KEYW: begin
                w_ra = NodeW'(r_i - 1'b1); s_ra = LeafW'(r_i - 1'b1);
            end
            S_SO_CMP: begin
                w_ra = NodeW'(r_j - 2'd2); s_ra = LeafW'(r_j - 2'd2);
                if (w_rd > r_w) begin
                    w_we = 1'b1; s_we = 1'b1;
                    w_wa = NodeW'(r_j); s_wa = LeafW'(r_j);
                    w_wd = w_rd; s_wd = s_rd;
                end
            end
            S_SO_PUT: begin
                w_we = 1'b1; s_we = 1'b1;
                w_wa = NodeW'(r_j); s_wa = LeafW'(r_j);
                w_wd = r_w; s_wd = r_s;
            end
            S_WL_INIT: begin
                l_we = 1'b1; l_wa = LeafW'(r_i); l_wd = NodeW'(r_i);
            end
            S_MG_RDA: l_ra = '0;
            S_MG_RDB: begin
                l_ra = LeafW'(1); w_ra = l_rd;
            end
            S_MG_WA: begin
                w_ra = l_rd;
                p_we = 1'b1; p_wa = r_a; p_wd = {r_next, 1'b0};
            end
            S_MG_WB: begin
                p_we = 1'b1; p_wa = r_b; p_wd = {r_next, 1'b1};
                w_we = 1'b1; w_wa = r_next; w_wd = r_wa + w_rd;
            end
            S_MG_SH: begin
                l_ra = LeafW'(r_k + 2'd2);
                if (r_k != '0) begin
                    l_we = 1'b1; l_wa = LeafW'(r_k - 1'b1); l_wd = l_rd;
                end
            end
            S_MG_SCAN: l_ra = LeafW'(r_pos);
            S_MG_SCANL: w_ra = l_rd;
            S_MG_INS: begin
                l_ra = LeafW'(r_k - 1'b1);
                if (r_k == r_pos) begin
                    l_we = 1'b1; l_wa = LeafW'(r_pos); l_wd = r_next;
                end
            end
            S_MG_INSW: begin
                l_we = 1'b1; l_wa = LeafW'(r_k); l_wd = l_rd;
            end
            S_CD_START: s_ra = LeafW'(r_i);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt <= '0;
            r_tvalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_tvalid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (r_cnt < CntW'(MaxSymbols)) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (s_axis_tlast) begin
                            r_i <= CntW'(1);
                            r_state <= S_SO_KEY;
                        end
                    end
                end
                // Insertion sort: r_w/r_s hold the key, r_j walks down.
                S_SO_KEY: begin
                    if (r_i >= r_cnt) begin
                        r_i <= '0;
                        r_state <= S_WL_INIT;
                    end else begin
                        r_state <= S_SO_KEYW;
                    end
                end
                S_SO_KEYW: begin
                    r_w <= w_rd;
                    r_s <= s_rd;
                    r_j <= r_i;
                    r_state <= S_SO_CMP;
                end
                S_SO_CMP: begin
                    if (w_rd > r_w) begin
                        r_j <= r_j - 1'b1;
                        if (r_j == CntW'(1)) begin
                            r_state <= S_SO_PUT;
                        end
                    end else begin
                        r_state <= S_SO_PUT;
                    end
                end
                S_SO_PUT: begin
                    r_i <= r_i + 1'b1;
                    r_state <= S_SO_KEY;
                end
                S_WL_INIT: begin
                    if (r_i + 1'b1 >= r_cnt) begin
                        r_i <= '0;
                        r_len <= r_cnt;
                        r_next <= NodeW'(r_cnt);
                        r_state <= (r_cnt >= CntW'(2)) ? S_MG_RDA : S_CD_START;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_MG_RDA: r_state <= S_MG_RDB;
                S_MG_RDB: begin
                    r_a <= l_rd;
                    r_state <= S_MG_WA;
                end
                S_MG_WA: begin
                    r_wa <= w_rd;
                    r_b <= l_rd;
                    r_state <= S_MG_WB;
                end
                S_MG_WB: begin
                    r_w <= r_wa + w_rd;
                    r_len <= r_len - 2'd2;
                    r_k <= '0;
                    r_state <= S_MG_SH;
                end
                S_MG_SH: begin
                    if (r_k == r_len) begin
                        r_pos <= '0;
                        r_state <= S_MG_SCAN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_MG_SCAN: begin
                    if (r_pos >= r_len) begin
                        r_k <= r_len;
                        r_state <= S_MG_INS;
                    end else begin
                        r_state <= S_MG_SCANL;
                    end
                end
                S_MG_SCANL: r_state <= S_MG_SCANW;
                S_MG_SCANW: begin
                    if (w_rd < r_w) begin
                        r_pos <= r_pos + 1'b1;
                        r_state <= S_MG_SCAN;
                    end else begin
                        r_k <= r_len;
                        r_state <= S_MG_INS;
                    end
                end
                S_MG_INS: begin
                    if (r_k == r_pos) begin
                        r_len <= r_len + 1'b1;
                        r_next <= r_next + 1'b1;
                        r_state <= (r_len != '0) ? S_MG_RDA : S_CD_START;
                    end else begin
                        r_state <= S_MG_INSW;
                    end
                end
                S_MG_INSW: begin
                    r_k <= r_k - 1'b1;
                    r_state <= S_MG_INS;
                end
                S_CD_START: begin
                    r_node <= NodeW'(r_i);
                    r_bits <= '0;
                    r_clen <= '0;
                    r_state <= S_CD_SYM;
                end
                S_CD_SYM: begin
                    r_s <= s_rd;
                    r_state <= S_CD_RD;
                end
                S_CD_RD: r_state <= S_CD_STEP;
                S_CD_STEP: begin
                    if (r_cnt == CntW'(1)) begin
                        r_clen <= 7'd1;
                        r_state <= S_CD_OUT;
                    end else if (r_node == root) begin
                        r_state <= S_CD_OUT;
                    end else begin
                        if (r_clen < 7'(CodeMaxLen)) begin
                            r_bits[r_clen[5:0]] <= p_rd[0];
                        end
                        r_clen <= r_clen + 1'b1;
                        r_node <= p_rd[NodeW:1];
                        r_state <= S_CD_RD;
                    end
                end
                S_CD_OUT: begin
                    if (out_load) begin
                        r_tdata <= {2'b00, code_len, r_bits, r_s};
                        r_tlast <= (r_i + 1'b1 == r_cnt);
                        if (r_i + 1'b1 == r_cnt) begin
                            r_cnt <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= S_CD_START;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = r_tvalid;
    assign m_axis_tdata  = r_tdata;
    assign m_axis_tlast  = r_tlast;

    `include "huffman_code_builder_assert.svh"
    `HCB_ASSERT_IMPL(a_ready_load, s_axis_tready, r_state == S_LOAD)
    `HCB_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `HCB_ASSERT_NEXT(a_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    `HCB_ASSERT_IMPL(a_cnt_max, 1'b1, r_cnt <= CntW'(MaxSymbols))
endmodule

[test/huffman_code_builder_tb.sv]
`timescale 1ns / 100ps

module huffman_code_builder_tb
    import hcb_pkg::*;
();

    typedef struct {
        logic [7:0]  sym;
        logic [47:0] bits;
        logic [5:0]  len;
        logic        last;
    } t_code;

    typedef struct {
        logic [7:0]  sym;
        logic [23:0] freq;
        logic        last;
        bit          typed;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic rdy_draw = 1'b0;
    logic hold_on = 1'b0;
    bit   hold_go = 0;
    bit   no_gaps = 0;
    int   errors = 0;
    int   cycles = 0;
    int   items_sent = 0;
    int   runs_built = 0;
    int   codes_seen = 0;

    t_code pending_codes[$];
    t_code typed_codes[$];

    logic [7:0]  leaf_sym[MaxSymbols];
    logic [31:0] node_w[NodeCount];
    logic [6:0]  node_up[NodeCount];
    logic        node_bit[NodeCount];
    int          leaf_cnt = 0;

    assign m_axis_tready = rdy_draw && !hold_on;

    huffman_code_builder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("FAIL huffman_code_builder");
            $finish;
        end
    end

    // Loads one pair and, on the last one, builds the tree and queues the codes.
    task automatic load_pair(input logic [7:0] sym, input logic [23:0] freq,
                             input logic last, output t_code codes[$]);
        int n, root, nxt, pos, a, b, node, len;
        logic [31:0] w;
        logic [7:0] s;
        logic [47:0] bits;
        int work[$];
        t_code c;
        codes = {};
        if (leaf_cnt < MaxSymbols) begin
            leaf_sym[leaf_cnt] = sym;
            node_w[leaf_cnt] = {8'd0, freq};
            leaf_cnt++;
        end
        if (!last) return;
        n = leaf_cnt;
        for (int i = 1; i < n; i++) begin
            int j;
            w = node_w[i];
            s = leaf_sym[i];
            j = i;
            while (j > 0 && node_w[j-1] > w) begin
                node_w[j] = node_w[j-1];
                leaf_sym[j] = leaf_sym[j-1];
                j--;
            end
            node_w[j] = w;
            leaf_sym[j] = s;
        end
        for (int i = 0; i < n; i++) work = {work, i};
        nxt = n;
        while (work.size() >= 2) begin
            a = work.pop_front();
            b = work.pop_front();
            w = node_w[a] + node_w[b];
            node_up[a] = 7'(nxt);
            node_bit[a] = 1'b0;
            node_up[b] = 7'(nxt);
            node_bit[b] = 1'b1;
            node_w[nxt] = w;
            pos = 0;
            while (pos < work.size() && node_w[work[pos]] < w) pos++;
            work.insert(pos, nxt);
            nxt++;
        end
        root = 2 * n - 2;
        for (int i = 0; i < n; i++) begin
            bits = '0;
            len = 0;
            node = i;
            if (n == 1) begin
                len = 1;
            end else begin
                while (node != root && len < NodeCount) begin
                    if (len < CodeMaxLen) bits[len] = node_bit[node];
                    len++;
                    node = node_up[node];
                end
            end
            if (len > CodeMaxLen) len = CodeMaxLen;
            c.sym = leaf_sym[i];
            c.bits = bits;
            c.len = 6'(len);
            c.last = (i == n - 1);
            codes = {codes, c};
        end
        leaf_cnt = 0;
    endtask

    task automatic send_item(input logic [7:0] sym, input logic [23:0] freq,
                             input logic last, input bit typed);
        int gap;
        t_code codes[$];
        t_code c;
        gap = no_gaps ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tdata <= {freq, sym};
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        items_sent++;
        load_pair(sym, freq, last, codes);
        if (last) runs_built++;
        foreach (codes[k]) begin
            if (typed) c = typed_codes.pop_front();
            else c = codes[k];
            pending_codes = {pending_codes, c};
        end
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_code e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            codes_seen++;
            if (pending_codes.size() == 0) begin
                errors++;
                $display("%0t: code beat exp none act sym %h", $time, m_axis_tdata[7:0]);
            end else begin
                e = pending_codes.pop_front();
                if (m_axis_tdata[7:0] !== e.sym) begin
                    errors++;
                    $display("%0t: symbol exp %h act %h", $time, e.sym, m_axis_tdata[7:0]);
                end
                if (m_axis_tdata[55:8] !== e.bits) begin
                    errors++;
                    $display("%0t: bits exp %h act %h", $time, e.bits, m_axis_tdata[55:8]);
                end
                if (m_axis_tdata[61:56] !== e.len) begin
                    errors++;
                    $display("%0t: length exp %0d act %0d", $time, e.len,
                             m_axis_tdata[61:56]);
                end
                if (m_axis_tlast !== e.last) begin
                    errors++;
                    $display("%0t: last exp %b act %b", $time, e.last, m_axis_tlast);
                end
            end
        end
    end

    initial begin
        int d;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            d = no_gaps ? 0 : $urandom_range(0, 10);
            if (d > 0) begin
                rdy_draw <= 1'b0;
                repeat (d) @(negedge i_clk);
            end
            rdy_draw <= 1'b1;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) @(posedge i_clk);
        end
    end

    // A long output stall that backs the block up while new pairs are offered.
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        hold_on <= 1'b1;
        repeat (800) @(negedge i_clk);
        hold_on <= 1'b0;
    end

    initial begin
        t_row table_rows[$];
        int run_len, kind;
        logic [23:0] f;
        table_rows = '{
            '{8'hFF, 24'hFFFFFF, 1'b1, 1'b1},
            '{8'h00, 24'h000001, 1'b0, 1'b1},
            '{8'hFF, 24'hFFFFFF, 1'b1, 1'b1},
            '{8'h55, 24'h000000, 1'b0, 1'b0},
            '{8'h55, 24'h000003, 1'b0, 1'b0},
            '{8'hAA, 24'h000003, 1'b0, 1'b0},
            '{8'h0F, 24'h000003, 1'b1, 1'b0},
            '{8'h01, 24'h000001, 1'b0, 1'b0},
            '{8'h02, 24'h000002, 1'b0, 1'b0},
            '{8'h03, 24'h000004, 1'b0, 1'b0},
            '{8'h04, 24'h000008, 1'b0, 1'b0},
            '{8'h05, 24'h000010, 1'b1, 1'b0},
            '{8'hA5, 24'hAAAAAA, 1'b0, 1'b0},
            '{8'h5A, 24'h555555, 1'b0, 1'b0},
            '{8'h3C, 24'h800000, 1'b1, 1'b0}
        };
        typed_codes = '{
            '{8'hFF, 48'd0, 6'd1, 1'b1},
            '{8'h00, 48'd0, 6'd1, 1'b0},
            '{8'hFF, 48'd1, 6'd1, 1'b1}
        };
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (table_rows[r])
            send_item(table_rows[r].sym, table_rows[r].freq, table_rows[r].last,
                      table_rows[r].typed);

        // All-zero weights form a chain deeper than the code width, and the
        // extra pairs past a full store are dropped.
        for (int i = 0; i < MaxSymbols + 2; i++)
            send_item(8'($urandom_range(0, 255)), 24'd0, i == MaxSymbols + 1, 1'b0);

        while (items_sent < 270) begin
            kind = $urandom_range(0, 19);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (runs_built == 8) hold_go = 1;
            if (kind == 0 && items_sent < 180) run_len = MaxSymbols;
            else if (kind < 4) run_len = $urandom_range(13, 30);
            else run_len = $urandom_range(1, 12);
            for (int i = 0; i < run_len; i++) begin
                case ($urandom_range(0, 5))
                    0: f = 24'($urandom_range(1, 4));
                    1: f = 24'($urandom_range(1, 255));
                    2: f = 24'd0;
                    default: f = 24'($urandom_range(1, 24'hFFFFFF));
                endcase
                send_item(8'($urandom_range(0, 255)), f, i == run_len - 1, 1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;
        no_gaps = 0;
        wait (pending_codes.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d pairs in %0d builds, %0d code beats checked.",
                 items_sent, runs_built, codes_seen);
        $display("Runs included a lone symbol, ties, zero weights and a full store.");
        if (errors == 0) begin
            $display("PASS huffman_code_builder");
        end else begin
            $display("FAIL huffman_code_builder");
        end
        $finish;
    end
endmodule
